[design/bilinear_upscale_defines.svh]
// Assertion macros shared by the bilinear upscaler RTL
`ifndef BILINEAR_UPSCALE_DEFINES_SVH
`define BILINEAR_UPSCALE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset
`define BLU_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define BLU_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[design/blu_pkg.sv]
// Shared types, constants and reciprocal tables of the bilinear upscaler
package blu_pkg;

  localparam int CRD_W = 11;  // coordinate fields
  localparam int IDX_W = 11;  // sample index / store coordinate
  localparam int DIM_W = 9;   // width and height registers
  localparam int SCL_W = 4;   // scale register
  localparam int CH_W  = 8;   // one color channel
  localparam int T_W   = 13;  // 2*coord + 1 + scale
  localparam int Q_W   = 12;  // axis quotient
  localparam int FRC_W = 5;   // axis fraction, below 2*scale
  localparam int WGT_W = 10;  // corner weight, up to (2*scale)^2
  localparam int PRD_W = 18;  // channel times weight, and the blend sum
  localparam int RCP1_W = 16;
  localparam int RCP2_W = 17;
  localparam int Q_DEPTH = 4;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE      = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } blu_pix_t;

  typedef struct packed {
    logic             is_write;
    logic             oor;
    logic [IDX_W-1:0] x0;
    logic [IDX_W-1:0] x1;
    logic [IDX_W-1:0] y0;
    logic [IDX_W-1:0] y1;
    logic [FRC_W-1:0] fx;
    logic [FRC_W-1:0] fy;
    logic [SCL_W-1:0] s;
    blu_pix_t         pix;
  } blu_cmd_t;

  // floor(2^16 / (2*s))
  function automatic logic [RCP1_W-1:0] rcp_axis(input logic [SCL_W-1:0] s);
    logic [RCP1_W-1:0] r;
    case (s)
      4'd1:    r = 16'd32768;
      4'd2:    r = 16'd16384;
      4'd3:    r = 16'd10922;
      4'd4:    r = 16'd8192;
      4'd5:    r = 16'd6553;
      4'd6:    r = 16'd5461;
      4'd7:    r = 16'd4681;
      4'd8:    r = 16'd4096;
      4'd9:    r = 16'd3640;
      4'd10:   r = 16'd3276;
      4'd11:   r = 16'd2978;
      4'd12:   r = 16'd2730;
      4'd13:   r = 16'd2520;
      4'd14:   r = 16'd2340;
      4'd15:   r = 16'd2184;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // floor(2^18 / (2*s)^2)
  function automatic logic [RCP2_W-1:0] rcp_blend(input logic [SCL_W-1:0] s);
    logic [RCP2_W-1:0] r;
    case (s)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd16384;
      4'd3:    r = 17'd7281;
      4'd4:    r = 17'd4096;
      4'd5:    r = 17'd2621;
      4'd6:    r = 17'd1820;
      4'd7:    r = 17'd1337;
      4'd8:    r = 17'd1024;
      4'd9:    r = 17'd809;
      4'd10:   r = 17'd655;
      4'd11:   r = 17'd541;
      4'd12:   r = 17'd455;
      4'd13:   r = 17'd387;
      4'd14:   r = 17'd334;
      4'd15:   r = 17'd291;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

[design/bilinear_upscale.sv]
// Top level of the bilinear integer-factor RGBA8 upscaler
// Write words (cmd 0) store one source pixel; read words (cmd 1) return one pixel of the
// image scaled up by the scale register, pixel-centre aligned, blended from four source
// neighbours and rounded half up, or flagged out_of_range with zero channels. While nothing
// stalls, the block takes one word per clock and returns one result per clock; a read result
// passes 4 front stages, the queue and 5 back stages. The frame store is split in four banks
// by row and column parity so that all four neighbours are read in the same cycle. Reads of
// pixels never written return undefined data. The user must write configuration only while
// the block is idle; the block itself does not enforce it.
module bilinear_upscale #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_SCALE      = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [blu_pkg::CRD_W-1:0]  in_coord_x,
  input  logic [blu_pkg::CRD_W-1:0]  in_coord_y,
  input  logic [blu_pkg::CH_W-1:0]   in_red,
  input  logic [blu_pkg::CH_W-1:0]   in_green,
  input  logic [blu_pkg::CH_W-1:0]   in_blue,
  input  logic [blu_pkg::CH_W-1:0]   in_alpha,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [blu_pkg::CH_W-1:0]   out_red,
  output logic [blu_pkg::CH_W-1:0]   out_green,
  output logic [blu_pkg::CH_W-1:0]   out_blue,
  output logic [blu_pkg::CH_W-1:0]   out_alpha,
  output logic                       out_of_range,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [blu_pkg::DIM_W-1:0]  cfg_data
);
  import blu_pkg::*;

  logic [DIM_W-1:0] src_width_r, src_height_r;
  logic [SCL_W-1:0] scale_r;
  blu_pix_t in_pix;
  logic q_push, q_full, q_pop, q_empty;
  blu_cmd_t q_wr, q_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= 9'd256;
      src_height_r <= 9'd256;
      scale_r      <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width_r  <= cfg_data;
        REG_SRC_HEIGHT: src_height_r <= cfg_data;
        REG_SCALE:      scale_r      <= cfg_data[SCL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pix.red   = in_red;
  assign in_pix.green = in_green;
  assign in_pix.blue  = in_blue;
  assign in_pix.alpha = in_alpha;

  blu_front #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
    .MAX_SCALE     (MAX_SCALE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y),
    .in_pix    (in_pix),
    .cfg_w     (src_width_r),
    .cfg_h     (src_height_r),
    .cfg_s     (scale_r),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_data    (q_wr)
  );

  blu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data(q_wr),
    .full   (q_full),
    .pop    (q_pop),
    .rd_data(q_rd),
    .empty  (q_empty)
  );

  blu_back #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_data      (q_rd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .out_of_range(out_of_range)
  );

endmodule

[design/blu_front.sv]
// Front end: takes words, range checks and computes sample indices and fractions
`include "bilinear_upscale_defines.svh"
module blu_front #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_SCALE      = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [blu_pkg::CRD_W-1:0]   in_coord_x,
  input  logic [blu_pkg::CRD_W-1:0]   in_coord_y,
  input  blu_pkg::blu_pix_t           in_pix,
  input  logic [blu_pkg::DIM_W-1:0]   cfg_w,
  input  logic [blu_pkg::DIM_W-1:0]   cfg_h,
  input  logic [blu_pkg::SCL_W-1:0]   cfg_s,
  output logic                        q_push,
  input  logic                        q_full,
  output blu_pkg::blu_cmd_t           q_data
);
  import blu_pkg::*;

  logic en;
  logic [DIM_W-1:0] w_sat, h_sat;
  logic [SCL_W-1:0] s_sat;
  logic in_store;

  // stage 0
  logic s0_v_r, s0_wr_r;
  logic [CRD_W-1:0] s0_cx_r, s0_cy_r;
  blu_pix_t s0_pix_r;
  logic [DIM_W-1:0] s0_w_r, s0_h_r;
  logic [SCL_W-1:0] s0_s_r;

  // stage 1
  logic [T_W-1:0] tx, ty;
  logic [28:0] pwx, pwy;
  logic [T_W-1:0] ws, hs;
  logic oor1;
  logic s1_v_r, s1_wr_r, s1_oor_r;
  logic [CRD_W-1:0] s1_cx_r, s1_cy_r;
  blu_pix_t s1_pix_r;
  logic [DIM_W-1:0] s1_w_r, s1_h_r;
  logic [SCL_W-1:0] s1_s_r;
  logic [T_W-1:0] s1_tx_r, s1_ty_r;
  logic [Q_W-1:0] s1_qx_r, s1_qy_r;

  // stage 2
  logic [FRC_W-1:0] d1;
  logic [16:0] remx, remy;
  logic [Q_W-1:0] qx2, qy2;
  logic [FRC_W-1:0] fx2, fy2;
  logic s2_v_r, s2_wr_r, s2_oor_r;
  logic [CRD_W-1:0] s2_cx_r, s2_cy_r;
  blu_pix_t s2_pix_r;
  logic [DIM_W-1:0] s2_w_r, s2_h_r;
  logic [SCL_W-1:0] s2_s_r;
  logic [Q_W-1:0] s2_qx_r, s2_qy_r;
  logic [FRC_W-1:0] s2_fx_r, s2_fy_r;

  // stage 3
  logic [DIM_W-1:0] wm1, hm1, x0c, x1c, y0c, y1c;
  logic [Q_W-1:0] qx0, qy0;
  logic s3_v_r;
  blu_cmd_t s3_r;

  assign en       = !s3_v_r || !q_full;
  assign in_ready = en;
  assign q_push   = s3_v_r && !q_full;
  assign q_data   = s3_r;

  always_comb begin
    w_sat = (int'(cfg_w) > MAX_SRC_WIDTH) ? DIM_W'(MAX_SRC_WIDTH) : cfg_w;
    h_sat = (int'(cfg_h) > MAX_SRC_HEIGHT) ? DIM_W'(MAX_SRC_HEIGHT) : cfg_h;
    s_sat = (int'(cfg_s) > MAX_SCALE) ? SCL_W'(MAX_SCALE) : cfg_s;
    in_store = (int'(in_coord_x) < MAX_SRC_WIDTH) && (int'(in_coord_y) < MAX_SRC_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      // writes outside the store are dropped here
      s0_v_r <= in_valid && (in_cmd == CMD_READ || in_store);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_wr_r  <= (in_cmd == CMD_WRITE);
      s0_cx_r  <= in_coord_x;
      s0_cy_r  <= in_coord_y;
      s0_pix_r <= in_pix;
      s0_w_r   <= w_sat;
      s0_h_r   <= h_sat;
      s0_s_r   <= s_sat;
    end
  end

  // t = 2*c + 1 + s, quotient estimate through the reciprocal of 2*s
  always_comb begin
    tx  = {1'b0, s0_cx_r, 1'b1} + T_W'(s0_s_r);
    ty  = {1'b0, s0_cy_r, 1'b1} + T_W'(s0_s_r);
    pwx = 29'(tx) * 29'(rcp_axis(s0_s_r));
    pwy = 29'(ty) * 29'(rcp_axis(s0_s_r));
    ws  = T_W'(s0_w_r) * T_W'(s0_s_r);
    hs  = T_W'(s0_h_r) * T_W'(s0_s_r);
    oor1 = (s0_w_r == '0) || (s0_h_r == '0) || (s0_s_r == '0) ||
           (T_W'(s0_cx_r) >= ws) || (T_W'(s0_cy_r) >= hs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_wr_r  <= s0_wr_r;
      s1_oor_r <= oor1;
      s1_cx_r  <= s0_cx_r;
      s1_cy_r  <= s0_cy_r;
      s1_pix_r <= s0_pix_r;
      s1_w_r   <= s0_w_r;
      s1_h_r   <= s0_h_r;
      s1_s_r   <= s0_s_r;
      s1_tx_r  <= tx;
      s1_ty_r  <= ty;
      s1_qx_r  <= pwx[27:16];
      s1_qy_r  <= pwy[27:16];
    end
  end

  // estimate is exact or one low; fix it with the remainder
  always_comb begin
    d1   = {s1_s_r, 1'b0};
    remx = 17'(s1_tx_r) - 17'(s1_qx_r) * 17'(d1);
    remy = 17'(s1_ty_r) - 17'(s1_qy_r) * 17'(d1);
    if (remx >= 17'(d1)) begin
      qx2 = s1_qx_r + 1'b1;
      fx2 = FRC_W'(remx - 17'(d1));
    end else begin
      qx2 = s1_qx_r;
      fx2 = FRC_W'(remx);
    end
    if (remy >= 17'(d1)) begin
      qy2 = s1_qy_r + 1'b1;
      fy2 = FRC_W'(remy - 17'(d1));
    end else begin
      qy2 = s1_qy_r;
      fy2 = FRC_W'(remy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_wr_r  <= s1_wr_r;
      s2_oor_r <= s1_oor_r;
      s2_cx_r  <= s1_cx_r;
      s2_cy_r  <= s1_cy_r;
      s2_pix_r <= s1_pix_r;
      s2_w_r   <= s1_w_r;
      s2_h_r   <= s1_h_r;
      s2_s_r   <= s1_s_r;
      s2_qx_r  <= qx2;
      s2_qy_r  <= qy2;
      s2_fx_r  <= fx2;
      s2_fy_r  <= fy2;
    end
  end

  // edge clamping of both neighbours
  always_comb begin
    wm1 = s2_w_r - 1'b1;
    hm1 = s2_h_r - 1'b1;
    qx0 = (s2_qx_r == '0) ? '0 : s2_qx_r - 1'b1;
    qy0 = (s2_qy_r == '0) ? '0 : s2_qy_r - 1'b1;
    x0c = (qx0 > Q_W'(wm1)) ? wm1 : DIM_W'(qx0);
    y0c = (qy0 > Q_W'(hm1)) ? hm1 : DIM_W'(qy0);
    x1c = (s2_qx_r < Q_W'(wm1)) ? DIM_W'(s2_qx_r) : wm1;
    y1c = (s2_qy_r < Q_W'(hm1)) ? DIM_W'(s2_qy_r) : hm1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r.is_write <= s2_wr_r;
      s3_r.oor      <= s2_oor_r;
      s3_r.x0       <= s2_wr_r ? s2_cx_r : IDX_W'(x0c);
      s3_r.x1       <= IDX_W'(x1c);
      s3_r.y0       <= s2_wr_r ? s2_cy_r : IDX_W'(y0c);
      s3_r.y1       <= IDX_W'(y1c);
      s3_r.fx       <= s2_fx_r;
      s3_r.fy       <= s2_fy_r;
      s3_r.s        <= s2_s_r;
      s3_r.pix      <= s2_pix_r;
    end
  end

  `BLU_CHECK(a_x_adjacent, !(s3_v_r && !s3_r.is_write && !s3_r.oor) || (s3_r.x1 == s3_r.x0) || (s3_r.x1 == s3_r.x0 + 1'b1), "x neighbours not adjacent")
  `BLU_CHECK(a_y_adjacent, !(s3_v_r && !s3_r.is_write && !s3_r.oor) || (s3_r.y1 == s3_r.y0) || (s3_r.y1 == s3_r.y0 + 1'b1), "y neighbours not adjacent")

endmodule

[design/blu_queue.sv]
// Short queue of decoded words between front and back end
`include "bilinear_upscale_defines.svh"
module blu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  blu_pkg::blu_cmd_t wr_data,
  output logic              full,
  input  logic              pop,
  output blu_pkg::blu_cmd_t rd_data,
  output logic              empty
);
  import blu_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);

  blu_cmd_t         slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;

  assign full    = (cnt_r == (PTR_W+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `BLU_CHECK(a_no_overflow, !(push && full), "push into full queue")
  `BLU_CHECK(a_no_underflow, !(pop && empty), "pop from empty queue")

endmodule

[design/blu_back.sv]
// Back end: banked frame store, four-tap blend and rounding divide
`include "bilinear_upscale_defines.svh"
module blu_back #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  blu_pkg::blu_cmd_t         q_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [blu_pkg::CH_W-1:0]  out_red,
  output logic [blu_pkg::CH_W-1:0]  out_green,
  output logic [blu_pkg::CH_W-1:0]  out_blue,
  output logic [blu_pkg::CH_W-1:0]  out_alpha,
  output logic                      out_of_range
);
  import blu_pkg::*;

  // each bank holds one parity of row and column
  localparam int HX = ($clog2(MAX_SRC_WIDTH) > 1) ? $clog2(MAX_SRC_WIDTH) - 1 : 1;
  localparam int HY = ($clog2(MAX_SRC_HEIGHT) > 1) ? $clog2(MAX_SRC_HEIGHT) - 1 : 1;
  localparam int BA_W = HX + HY;
  localparam int BANK_DEPTH = 1 << BA_W;

  logic en;
  logic [BA_W-1:0] addr [4];
  logic [3:0] we;
  blu_pix_t rd_r [4];

  logic [FRC_W-1:0] d0, dfx, dfy;
  logic b0_v_r, b0_oor_r, b0_x0p_r, b0_x1p_r, b0_y0p_r, b0_y1p_r;
  logic [SCL_W-1:0] b0_s_r;
  logic [WGT_W-1:0] b0_wgt_r [4];

  blu_pix_t px [4];
  logic b1_v_r, b1_oor_r;
  logic [SCL_W-1:0] b1_s_r;
  logic [7:0] b1_sq_r;
  logic [PRD_W-1:0] b1_prod_r [4][4];

  logic b2_v_r, b2_oor_r;
  logic [WGT_W-1:0] b2_dd_r;
  logic [RCP2_W-1:0] b2_rcp_r;
  logic [PRD_W-1:0] b2_sum_r [4];

  logic [34:0] pe [4];
  logic b3_v_r, b3_oor_r;
  logic [WGT_W-1:0] b3_dd_r;
  logic [PRD_W-1:0] b3_sum_r [4];
  logic [8:0] b3_qe_r [4];

  logic [PRD_W-1:0] rem [4];
  logic [8:0] res [4];
  logic o_v_r, o_oor_r;
  logic [CH_W-1:0] o_ch_r [4];

  assign en    = !o_v_r || out_ready;
  assign q_pop = en && !q_empty;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [IDX_W-1:0] bx, by;
      bx = (q_data.x0[0] == b[0]) ? q_data.x0 : q_data.x1;
      by = (q_data.y0[0] == b[1]) ? q_data.y0 : q_data.y1;
      addr[b] = {HY'(by >> 1), HX'(bx >> 1)};
      we[b] = q_pop && q_data.is_write && (q_data.x0[0] == b[0]) && (q_data.y0[0] == b[1]);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    blu_pix_t mem [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (we[g]) begin
        mem[addr[g]] <= q_data.pix;
      end
      if (en) begin
        rd_r[g] <= mem[addr[g]];
      end
    end
  end

  always_comb begin
    d0  = {q_data.s, 1'b0};
    dfx = d0 - q_data.fx;
    dfy = d0 - q_data.fy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (en) begin
      b0_v_r <= q_pop && !q_data.is_write;
      b1_v_r <= b0_v_r;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      o_v_r  <= b3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_oor_r <= q_data.oor;
      b0_x0p_r <= q_data.x0[0];
      b0_x1p_r <= q_data.x1[0];
      b0_y0p_r <= q_data.y0[0];
      b0_y1p_r <= q_data.y1[0];
      b0_s_r   <= q_data.s;
      b0_wgt_r[0] <= WGT_W'(dfx) * WGT_W'(dfy);
      b0_wgt_r[1] <= WGT_W'(q_data.fx) * WGT_W'(dfy);
      b0_wgt_r[2] <= WGT_W'(dfx) * WGT_W'(q_data.fy);
      b0_wgt_r[3] <= WGT_W'(q_data.fx) * WGT_W'(q_data.fy);
    end
  end

  // corners: top-left, top-right, bottom-left, bottom-right
  always_comb begin
    px[0] = rd_r[{b0_y0p_r, b0_x0p_r}];
    px[1] = rd_r[{b0_y0p_r, b0_x1p_r}];
    px[2] = rd_r[{b0_y1p_r, b0_x0p_r}];
    px[3] = rd_r[{b0_y1p_r, b0_x1p_r}];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_oor_r <= b0_oor_r;
      b1_s_r   <= b0_s_r;
      b1_sq_r  <= 8'(b0_s_r) * 8'(b0_s_r);
      for (int k = 0; k < 4; k++) begin
        b1_prod_r[0][k] <= PRD_W'(px[k].red)   * PRD_W'(b0_wgt_r[k]);
        b1_prod_r[1][k] <= PRD_W'(px[k].green) * PRD_W'(b0_wgt_r[k]);
        b1_prod_r[2][k] <= PRD_W'(px[k].blue)  * PRD_W'(b0_wgt_r[k]);
        b1_prod_r[3][k] <= PRD_W'(px[k].alpha) * PRD_W'(b0_wgt_r[k]);
      end
    end
  end

  // sum plus half of d*d for round half up
  always_ff @(posedge clk) begin
    if (en) begin
      b2_oor_r <= b1_oor_r;
      b2_dd_r  <= {b1_sq_r, 2'b00};
      b2_rcp_r <= rcp_blend(b1_s_r);
      for (int c = 0; c < 4; c++) begin
        b2_sum_r[c] <= b1_prod_r[c][0] + b1_prod_r[c][1] + b1_prod_r[c][2] +
                       b1_prod_r[c][3] + PRD_W'({b1_sq_r, 1'b0});
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      pe[c] = 35'(b2_sum_r[c]) * 35'(b2_rcp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_oor_r <= b2_oor_r;
      b3_dd_r  <= b2_dd_r;
      for (int c = 0; c < 4; c++) begin
        b3_sum_r[c] <= b2_sum_r[c];
        b3_qe_r[c]  <= pe[c][26:18];
      end
    end
  end

  // quotient estimate is exact or one low
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rem[c] = b3_sum_r[c] - PRD_W'(b3_qe_r[c]) * PRD_W'(b3_dd_r);
      res[c] = (rem[c] >= PRD_W'(b3_dd_r)) ? b3_qe_r[c] + 1'b1 : b3_qe_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_oor_r <= b3_oor_r;
      for (int c = 0; c < 4; c++) begin
        o_ch_r[c] <= b3_oor_r ? '0 : res[c][CH_W-1:0];
      end
    end
  end

  assign out_valid    = o_v_r;
  assign out_of_range = o_oor_r;
  assign out_red      = o_ch_r[0];
  assign out_green    = o_ch_r[1];
  assign out_blue     = o_ch_r[2];
  assign out_alpha    = o_ch_r[3];

  `BLU_CHECK(a_blend_fits, !(en && b3_v_r && !b3_oor_r) || !(res[0][8] || res[1][8] || res[2][8] || res[3][8]), "blend exceeds channel range")
  `BLU_CHECK_NEXT(a_result_follows, en && b3_v_r, o_v_r, "result lost at output stage")

endmodule
